FILE: hw/rtl/qtt_pkg.sv
package qtt_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 16;

   localparam int TAG_W     = 4;
   localparam int KIND_W    = 2;
   localparam int CNT_W     = 3;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int OP_W      = 2;
   localparam int NOW_W     = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

   // operation codes
   localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
   localparam logic [OP_W-1:0] OP_REPLY = 2'd1;
   localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUORUM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd2;

   localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd20;
   localparam logic [CNT_W-1:0] QUORUM_RST  = 3'd2;
   localparam logic [CNT_W-1:0] LIMIT_RST   = 3'd3;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [TAG_W-1:0]  trans_tag;
      logic [KIND_W-1:0] request_kind;
      logic              reply_ok;
      logic              reply_has_value;
      logic [NOW_W-1:0]  now;
   } req_word_type;

   typedef struct packed {
      logic [TAG_W-1:0]  done_tag;
      logic [KIND_W-1:0] done_kind;
      logic              succeeded;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CNT_W-1:0]  replies;
      logic [CNT_W-1:0]  successes;
   } slot_meta_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPEN,
      ST_REPLY,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;      // capture request word, read its slot
      logic open_wr;     // write a fresh slot
      logic reply_upd;   // write back counters, emit verdict if any
      logic sweep_step;  // check one slot, advance index
      logic flush;       // emit held verdict as last
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] req_op;
      logic            out_free;
      logic            slot_fin;
      logic            idx_last;
      logic            held_valid;
   } dp_status_type;

endpackage

FILE: hw/rtl/qtt_control.sv
module qtt_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  qtt_pkg::dp_status_type sts,
   output qtt_pkg::ctrl_cmd_type  cmd
);

   qtt_pkg::state_type state_ff;
   qtt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qtt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         qtt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (sts.req_op)
                  qtt_pkg::OP_OPEN:  state_in = qtt_pkg::ST_OPEN;
                  qtt_pkg::OP_REPLY: state_in = qtt_pkg::ST_REPLY;
                  qtt_pkg::OP_SWEEP: state_in = qtt_pkg::ST_SWEEP;
                  default:           state_in = qtt_pkg::ST_IDLE;
               endcase
            end
         end
         qtt_pkg::ST_OPEN: begin
            cmd.open_wr = 1'b1;
            state_in    = qtt_pkg::ST_IDLE;
         end
         qtt_pkg::ST_REPLY: begin
            if (!sts.slot_fin || sts.out_free) begin
               cmd.reply_upd = 1'b1;
               state_in      = qtt_pkg::ST_IDLE;
            end
         end
         qtt_pkg::ST_SWEEP: begin
            // a new verdict pushes the held one out, so it needs the output free
            if (!(sts.slot_fin && sts.held_valid) || sts.out_free) begin
               cmd.sweep_step = 1'b1;
               if (sts.idx_last) begin
                  state_in = qtt_pkg::ST_FLUSH;
               end
            end
         end
         qtt_pkg::ST_FLUSH: begin
            if (!sts.held_valid || sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = qtt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qtt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/qtt_datapath.sv
module qtt_datapath #(
   parameter int SLOTS     = qtt_pkg::SLOTS_DEF,
   parameter int TIME_BITS = qtt_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  qtt_pkg::req_word_type          req_word,
   input  logic                           csr_we,
   input  logic [qtt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qtt_pkg::CFG_W-1:0]      csr_wdata,
   input  qtt_pkg::ctrl_cmd_type          cmd,
   output qtt_pkg::dp_status_type         sts,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output qtt_pkg::rsp_word_type          rsp_word
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CMP_W = (TIME_BITS > qtt_pkg::CFG_W) ? TIME_BITS : qtt_pkg::CFG_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   // configuration
   logic [qtt_pkg::CFG_W-1:0] timeout_ff;
   logic [qtt_pkg::CNT_W-1:0] quorum_ff;
   logic [qtt_pkg::CNT_W-1:0] limit_ff;

   // captured item
   logic [qtt_pkg::OP_W-1:0]   op_ff;
   logic                       tag_ok_ff;
   logic [qtt_pkg::KIND_W-1:0] kind_ff;
   logic                       succ_flag_ff;
   logic [TIME_BITS-1:0]       now_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [SLOTS-1:0] live_ff;

   // slot table
   qtt_pkg::slot_meta_type slot_meta  [SLOTS];
   logic [TIME_BITS-1:0]   slot_start [SLOTS];
   qtt_pkg::slot_meta_type rd_meta_ff;
   logic [TIME_BITS-1:0]   rd_start_ff;
   qtt_pkg::slot_meta_type wr_meta;
   logic                   meta_we;
   logic                   rd_en;

   // verdict held back during a sweep until we know whether it is the last one
   logic                       held_valid_ff;
   logic [qtt_pkg::TAG_W-1:0]  held_tag_ff;
   logic [qtt_pkg::KIND_W-1:0] held_kind_ff;
   logic                       held_succ_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   qtt_pkg::rsp_word_type rsp_word_ff;
   qtt_pkg::rsp_word_type push_word;
   logic                  push;

   logic                       is_reply;
   logic                       check_live;
   logic [qtt_pkg::CNT_W-1:0]  rep_inc;
   logic [qtt_pkg::CNT_W-1:0]  succ_inc;
   logic [qtt_pkg::CNT_W-1:0]  rep_v;
   logic [qtt_pkg::CNT_W-1:0]  succ_v;
   logic [TIME_BITS-1:0]       elapsed;
   logic                       win;
   logic                       fail;
   logic                       slot_fin;
   logic                       out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= qtt_pkg::TIMEOUT_RST;
         quorum_ff  <= qtt_pkg::QUORUM_RST;
         limit_ff   <= qtt_pkg::LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            qtt_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            qtt_pkg::CSR_QUORUM:  quorum_ff  <= csr_wdata[qtt_pkg::CNT_W-1:0];
            qtt_pkg::CSR_LIMIT:   limit_ff   <= csr_wdata[qtt_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_word.operation;
         tag_ok_ff    <= (32'(req_word.trans_tag) < 32'(SLOTS));
         kind_ff      <= req_word.request_kind;
         succ_flag_ff <= req_word.reply_ok | req_word.reply_has_value;
         now_ff       <= TIME_BITS'(req_word.now);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = (req_word.operation == qtt_pkg::OP_SWEEP) ? '0
                                                            : IDX_W'(req_word.trans_tag);
      end else if (cmd.sweep_step) begin
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // slot check; a reply checks its freshly counted values
   assign is_reply   = (op_ff == qtt_pkg::OP_REPLY);
   assign check_live = live_ff[idx_ff] & (tag_ok_ff | ~is_reply);
   assign rep_inc    = (rd_meta_ff.replies == qtt_pkg::CNT_MAX) ? rd_meta_ff.replies
                                                                : rd_meta_ff.replies + 1'b1;
   assign succ_inc   = (succ_flag_ff && rd_meta_ff.successes != qtt_pkg::CNT_MAX)
                       ? rd_meta_ff.successes + 1'b1 : rd_meta_ff.successes;
   assign rep_v      = is_reply ? rep_inc  : rd_meta_ff.replies;
   assign succ_v     = is_reply ? succ_inc : rd_meta_ff.successes;
   assign elapsed    = now_ff - rd_start_ff;
   assign win        = (succ_v >= quorum_ff);
   assign fail       = (rep_v >= limit_ff) || (CMP_W'(elapsed) > CMP_W'(timeout_ff));
   assign slot_fin   = check_live & (win | fail);

   always_comb begin
      wr_meta = rd_meta_ff;
      meta_we = 1'b0;
      if (cmd.open_wr) begin
         wr_meta.kind      = kind_ff;
         wr_meta.replies   = '0;
         wr_meta.successes = '0;
         meta_we           = tag_ok_ff;
      end else if (cmd.reply_upd) begin
         wr_meta.replies   = rep_inc;
         wr_meta.successes = succ_inc;
         meta_we           = check_live;
      end
   end

   assign rd_en = cmd.accept | cmd.sweep_step;

   always_ff @(posedge clock) begin
      if (meta_we) begin
         slot_meta[idx_ff] <= wr_meta;
      end
      if (cmd.open_wr && tag_ok_ff) begin
         slot_start[idx_ff] <= now_ff;
      end
      if (rd_en) begin
         rd_meta_ff  <= slot_meta[idx_in];
         rd_start_ff <= slot_start[idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         if (cmd.open_wr && tag_ok_ff) begin
            live_ff[idx_ff] <= 1'b1;
         end
         if ((cmd.reply_upd || cmd.sweep_step) && slot_fin) begin
            live_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (cmd.sweep_step && slot_fin) begin
         held_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         held_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_step && slot_fin) begin
         held_tag_ff  <= qtt_pkg::TAG_W'(idx_ff);
         held_kind_ff <= rd_meta_ff.kind;
         held_succ_ff <= win;
      end
   end

   always_comb begin
      push      = 1'b0;
      push_word = '0;
      if (cmd.reply_upd && slot_fin) begin
         push                = 1'b1;
         push_word.done_tag  = qtt_pkg::TAG_W'(idx_ff);
         push_word.done_kind = rd_meta_ff.kind;
         push_word.succeeded = win;
         push_word.last      = 1'b1;
      end else if ((cmd.sweep_step && slot_fin && held_valid_ff) ||
                   (cmd.flush && held_valid_ff)) begin
         push                = 1'b1;
         push_word.done_tag  = held_tag_ff;
         push_word.done_kind = held_kind_ff;
         push_word.succeeded = held_succ_ff;
         push_word.last      = cmd.flush;
      end
   end

   assign rsp_valid_in = push | (rsp_valid_ff & rsp_stall);
   assign out_free     = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_word_ff <= push_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign sts.req_op     = req_word.operation;
   assign sts.out_free   = out_free;
   assign sts.slot_fin   = slot_fin;
   assign sts.idx_last   = (idx_ff == IDX_LAST);
   assign sts.held_valid = held_valid_ff;

endmodule

FILE: hw/rtl/quorum_transaction_tracker_top.sv
// Channel   Direction  Ports                          Moves
// request   in         req_valid req_stall req_word   one open, reply or sweep word
// response  out        rsp_valid rsp_stall rsp_word   one verdict word
// config    in         csr_we csr_index csr_wdata     one register write
//
// Open and reply: an accept step, then one slot read-modify-write on the
// single-port slot table. A sweep checks one slot per cycle. Output stalls
// hold the engine, sweep included, only when a verdict must be pushed into a
// full output register. Reset is synchronous; it clears live marks and config.
module quorum_transaction_tracker_top #(
   parameter int SLOTS     = qtt_pkg::SLOTS_DEF,
   parameter int TIME_BITS = qtt_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  qtt_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output qtt_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_we,
   input  logic [qtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qtt_pkg::CFG_W-1:0]     csr_wdata
);

   qtt_pkg::ctrl_cmd_type  cmd;
   qtt_pkg::dp_status_type sts;

   qtt_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   qtt_datapath #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.open_wr, cmd.reply_upd, cmd.sweep_step, cmd.flush}))
      else $error("more than one datapath command at once");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.operation != qtt_pkg::OP_NONE) |=> req_stall)
      else $error("request taken while previous word still in work");

   a_held_not_lost: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_step && sts.slot_fin && sts.held_valid) |-> sts.out_free)
      else $error("held verdict overwritten while output register is full");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !sts.held_valid)
      else $error("held verdict left over after sweep");
`endif

endmodule

FILE: tb/qtt_verdict_checker.sv
`timescale 1ns / 100ps

module qtt_verdict_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  qtt_pkg::req_word_type         req_word,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  qtt_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_we,
   input  logic [qtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qtt_pkg::CFG_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            outstanding
);

   typedef enum logic [1:0] {
      SLOT_STAYS,
      SLOT_FAILED,
      SLOT_PASSED
   } verdict_type;

   logic [qtt_pkg::CFG_W-1:0]  timeout_ticks;
   logic [qtt_pkg::CNT_W-1:0]  quorum;
   logic [qtt_pkg::CNT_W-1:0]  reply_limit;

   logic                       live      [qtt_pkg::SLOTS_DEF];
   logic [qtt_pkg::KIND_W-1:0] kind      [qtt_pkg::SLOTS_DEF];
   logic [qtt_pkg::CNT_W-1:0]  replies   [qtt_pkg::SLOTS_DEF];
   logic [qtt_pkg::CNT_W-1:0]  wins      [qtt_pkg::SLOTS_DEF];
   logic [qtt_pkg::NOW_W-1:0]  started   [qtt_pkg::SLOTS_DEF];

   qtt_pkg::rsp_word_type      verdict_q [$];

   function automatic verdict_type judge_slot(input logic [qtt_pkg::TAG_W-1:0] s,
                                              input logic [qtt_pkg::NOW_W-1:0] now);
      logic [qtt_pkg::NOW_W-1:0] elapsed;
      if (wins[s] >= quorum) return SLOT_PASSED;
      elapsed = now - started[s];  // wraps modulo 2^16
      if (replies[s] >= reply_limit || elapsed > timeout_ticks) return SLOT_FAILED;
      return SLOT_STAYS;
   endfunction

   task automatic track_word(input qtt_pkg::req_word_type w);
      verdict_type               v;
      qtt_pkg::rsp_word_type     held;
      bit                        have_held;
      logic [qtt_pkg::TAG_W-1:0] t;
      logic [qtt_pkg::TAG_W-1:0] s;
      t = w.trans_tag;
      have_held = 1'b0;
      case (w.operation)
         qtt_pkg::OP_OPEN: begin
            kind[t]    = w.request_kind;
            replies[t] = '0;
            wins[t]    = '0;
            started[t] = w.now;
            live[t]    = 1'b1;
         end
         qtt_pkg::OP_REPLY: begin
            if (live[t]) begin
               if (replies[t] != qtt_pkg::CNT_MAX) replies[t]++;
               if ((w.reply_ok || w.reply_has_value) && wins[t] != qtt_pkg::CNT_MAX) wins[t]++;
               v = judge_slot(t, w.now);
               if (v != SLOT_STAYS) begin
                  verdict_q.push_back('{done_tag: t, done_kind: kind[t],
                                        succeeded: (v == SLOT_PASSED), last: 1'b1});
                  live[t] = 1'b0;
               end
            end
         end
         qtt_pkg::OP_SWEEP: begin
            // hold each verdict back one step so the final one can carry last
            for (int i = 0; i < qtt_pkg::SLOTS_DEF; i++) begin
               s = i[qtt_pkg::TAG_W-1:0];
               if (live[s]) begin
                  v = judge_slot(s, w.now);
                  if (v != SLOT_STAYS) begin
                     if (have_held) verdict_q.push_back(held);
                     held = '{done_tag: s, done_kind: kind[s],
                              succeeded: (v == SLOT_PASSED), last: 1'b0};
                     have_held = 1'b1;
                     live[s] = 1'b0;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               verdict_q.push_back(held);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_word(input qtt_pkg::rsp_word_type got);
      qtt_pkg::rsp_word_type want;
      if (verdict_q.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected verdict word: tag %0d kind %0d ok %0b last %0b",
                     got.done_tag, got.done_kind, got.succeeded, got.last);
         mismatches++;
      end else begin
         want = verdict_q.pop_front();
         if (got.done_tag !== want.done_tag || got.done_kind !== want.done_kind ||
             got.succeeded !== want.succeeded || got.last !== want.last) begin
            if (mismatches < 10)
               $display("verdict mismatch: expected tag %0d kind %0d ok %0b last %0b, %s",
                        want.done_tag, want.done_kind, want.succeeded, want.last,
                        $sformatf("got tag %0d kind %0d ok %0b last %0b",
                                  got.done_tag, got.done_kind, got.succeeded, got.last));
            mismatches++;
         end
      end
   endtask

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         timeout_ticks = qtt_pkg::TIMEOUT_RST;
         quorum        = qtt_pkg::QUORUM_RST;
         reply_limit   = qtt_pkg::LIMIT_RST;
         live          = '{default: 1'b0};
         verdict_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_word(rsp_word);
         if (csr_we) begin
            case (csr_index)
               qtt_pkg::CSR_TIMEOUT: timeout_ticks = csr_wdata;
               qtt_pkg::CSR_QUORUM:  quorum        = csr_wdata[qtt_pkg::CNT_W-1:0];
               qtt_pkg::CSR_LIMIT:   reply_limit   = csr_wdata[qtt_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_word(req_word);
      end
      outstanding = verdict_q.size();
   end

endmodule

FILE: tb/tb_quorum_transaction_tracker_top.sv
`timescale 1ns / 100ps

module tb_quorum_transaction_tracker_top;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   qtt_pkg::req_word_type         req_word;
   logic                          rsp_valid;
   logic                          rsp_stall;
   qtt_pkg::rsp_word_type         rsp_word;
   logic                          csr_we;
   logic [qtt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [qtt_pkg::CFG_W-1:0]     csr_wdata;

   int                            fail_count;
   int                            waiting;
   bit                            req_calm = 1'b0;
   bit                            rsp_calm = 1'b0;
   logic [qtt_pkg::NOW_W-1:0]     now_t;
   logic [qtt_pkg::TAG_W-1:0]     recent [4];

   quorum_transaction_tracker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   qtt_verdict_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (fail_count),
      .outstanding (waiting)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic qtt_pkg::req_word_type make_word(
         input logic [qtt_pkg::OP_W-1:0]   op,
         input logic [qtt_pkg::TAG_W-1:0]  tag,
         input logic [qtt_pkg::KIND_W-1:0] kind,
         input logic                       ok,
         input logic                       hv,
         input logic [qtt_pkg::NOW_W-1:0]  now);
      qtt_pkg::req_word_type w;
      w.operation       = op;
      w.trans_tag       = tag;
      w.request_kind    = kind;
      w.reply_ok        = ok;
      w.reply_has_value = hv;
      w.now             = now;
      return w;
   endfunction

   // called right after a rising edge; returns at the edge that takes the word
   task automatic send_word(input qtt_pkg::req_word_type w);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (waiting != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      // a quiet sweep may still be walking the table
      repeat (40) @(posedge clock);
   endtask

   task automatic write_config(input logic [qtt_pkg::CFG_W-1:0] timeout,
                               input logic [qtt_pkg::CNT_W-1:0] quorum,
                               input logic [qtt_pkg::CNT_W-1:0] limit);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= qtt_pkg::CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= qtt_pkg::CSR_QUORUM;
      csr_wdata <= {{(qtt_pkg::CFG_W-qtt_pkg::CNT_W){1'b0}}, quorum};
      @(posedge clock);
      csr_index <= qtt_pkg::CSR_LIMIT;
      csr_wdata <= {{(qtt_pkg::CFG_W-qtt_pkg::CNT_W){1'b0}}, limit};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int                         n;
      int                         r;
      int                         step;
      int                         rnd;
      logic [qtt_pkg::TAG_W-1:0]  tag;
      logic [qtt_pkg::KIND_W-1:0] kind;
      qtt_pkg::req_word_type      w;
      n = 0;
      while (n < count) begin
         r    = $urandom_range(0, 99);
         step = $urandom_range(0, 19);
         if (step == 0) rnd = $urandom_range(0, 65535);
         else if (step < 4) rnd = int'(now_t) + $urandom_range(0, 30);
         else rnd = int'(now_t) + $urandom_range(0, 3);
         now_t = rnd[qtt_pkg::NOW_W-1:0];
         rnd   = $urandom_range(0, 15);
         tag   = rnd[qtt_pkg::TAG_W-1:0];
         rnd   = $urandom_range(0, 3);
         kind  = rnd[qtt_pkg::KIND_W-1:0];
         w = make_word(qtt_pkg::OP_OPEN, tag, kind, ($urandom_range(0, 1) == 1),
                       ($urandom_range(0, 1) == 1), now_t);
         if (r < 30) begin
            recent[2'($urandom_range(0, 3))] = tag;
            n++;
         end else if (r < 85) begin
            w.operation       = qtt_pkg::OP_REPLY;
            w.trans_tag       = recent[2'($urandom_range(0, 3))];
            w.reply_has_value = ($urandom_range(0, 3) == 0);
            n++;
         end else if (r < 93) begin
            w.operation = qtt_pkg::OP_SWEEP;
            n++;
         end else if (r < 96) begin
            w.operation = qtt_pkg::OP_NONE;
         end else begin
            w.operation = qtt_pkg::OP_REPLY;  // stray reply, often to a dead slot
         end
         send_word(w);
      end
      settle();
   endtask

   // response side: a fresh stall draw for every word
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      int cfg_t;
      int cfg_q;
      int cfg_l;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_we    <= 1'b0;
      csr_index <= qtt_pkg::CSR_TIMEOUT;
      csr_wdata <= '0;
      recent = '{default: '0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset config: timeout 20, quorum 2, limit 3
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd0,  2'd0, 1'b0, 1'b0, 16'd100));
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd15, 2'd3, 1'b1, 1'b1, 16'd100));
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd0,  2'd0, 1'b1, 1'b0, 16'd101));
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd0,  2'd3, 1'b0, 1'b1, 16'd102));
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd0,  2'd0, 1'b1, 1'b0, 16'd103));  // stray reply, slot already freed
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd15, 2'd0, 1'b0, 1'b0, 16'd104));
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd15, 2'd0, 1'b0, 1'b0, 16'd105));
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd15, 2'd0, 1'b0, 1'b0, 16'd106));  // hits limit
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd3,  2'd1, 1'b0, 1'b0, 16'd65530));
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd3,  2'd2, 1'b0, 1'b0, 16'hFFFF));  // overwrite
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd3,  2'd0, 1'b0, 1'b0, 16'd19));   // elapsed 20
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd3,  2'd0, 1'b0, 1'b0, 16'd20));   // elapsed 21
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd7,  2'd1, 1'b0, 1'b0, 16'd0));
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd8,  2'd2, 1'b0, 1'b0, 16'd0));
      send_word(make_word(qtt_pkg::OP_OPEN,  4'd9,  2'd3, 1'b0, 1'b0, 16'd10));
      send_word(make_word(qtt_pkg::OP_SWEEP, 4'd0,  2'd0, 1'b0, 1'b0, 16'd20));   // nothing due
      send_word(make_word(qtt_pkg::OP_SWEEP, 4'hF,  2'd3, 1'b1, 1'b1, 16'd21));   // two verdicts
      send_word(make_word(qtt_pkg::OP_NONE,  4'hF,  2'd3, 1'b1, 1'b1, 16'hFFFF));
      send_word(make_word(qtt_pkg::OP_REPLY, 4'd9,  2'd0, 1'b1, 1'b1, 16'd30));
      send_word(make_word(qtt_pkg::OP_SWEEP, 4'd0,  2'd0, 1'b0, 1'b0, 16'd30));
      send_word(make_word(qtt_pkg::OP_SWEEP, 4'd0,  2'd0, 1'b0, 1'b0, 16'd31));   // one verdict
      settle();

      now_t = 16'd1000;
      write_config(16'hFFFF, 3'd7, 3'd7);
      random_phase(50);
      write_config(16'd1, 3'd1, 3'd1);
      random_phase(50);
      write_config(16'd300, 3'd0, 3'd5);   // zero quorum: every check passes
      random_phase(40);
      write_config(16'd40, 3'd4, 3'd0);    // zero limit: every check without quorum fails
      random_phase(40);
      write_config(16'd0, 3'd7, 3'd2);
      random_phase(40);
      write_config(qtt_pkg::TIMEOUT_RST, qtt_pkg::QUORUM_RST, qtt_pkg::LIMIT_RST);
      random_phase(60);
      for (int p = 0; p < 3; p++) begin
         cfg_t = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                             : $urandom_range(5, 80);
         cfg_q = $urandom_range(1, 7);
         cfg_l = $urandom_range(1, 7);
         write_config(cfg_t[qtt_pkg::CFG_W-1:0], cfg_q[qtt_pkg::CNT_W-1:0],
                      cfg_l[qtt_pkg::CNT_W-1:0]);
         random_phase(25);
      end

      if (fail_count == 0 && waiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/qtt_pkg.sv
hw/rtl/qtt_control.sv
hw/rtl/qtt_datapath.sv
hw/rtl/quorum_transaction_tracker_top.sv
tb/qtt_verdict_checker.sv
tb/tb_quorum_transaction_tracker_top.sv
